// ===== rtl/rbt_pkg.sv =====
// Package for the retry backoff table: widths, reset values, codes and the record type.
// Used by rbt_store, retry_backoff_table and rbt_checker.
package rbt_pkg;

   localparam int unsigned TABLE_ENTRIES_DEF = 16;
   localparam int unsigned MAX_EXPONENT_DEF  = 15;

   localparam int unsigned KEY_W      = 32;
   localparam int unsigned TIME_W     = 48;
   localparam int unsigned CNT_W      = 8;
   localparam int unsigned BASE_W     = 24;
   localparam int unsigned MAXI_W     = 40;
   localparam int unsigned CSR_DATA_W = 64;
   localparam int unsigned CSR_ADDR_W = 4;

   localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(30000);
   localparam logic [MAXI_W-1:0] MAXI_RESET = MAXI_W'(43200000);
   localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
   localparam logic [TIME_W-1:0] TIME_MAX   = '1;

   typedef enum logic [1:0] {
      OP_QUERY   = 2'd0,
      OP_SUCCESS = 2'd1,
      OP_FAILURE = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_CHANGED   = 2'd0,
      STATUS_NO_CHANGE = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // register index = paddr[3] (registers sit 8 bytes apart)
   typedef enum logic {
      REG_BASE_INTERVAL = 1'b0,
      REG_MAX_RETRY     = 1'b1
   } reg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [CNT_W-1:0]  count;
      logic [TIME_W-1:0] last;
      logic [TIME_W-1:0] next;
   } rec_type;

endpackage

// ===== rtl/retry_backoff_table.sv =====
// Retry backoff table: per-key failure records with truncated binary exponential backoff.
// Depends on rbt_pkg and rbt_store.
//
//   channel   ports                                       handshake
//   --------  ------------------------------------------  ------------------------------
//   request   req_operation req_request_key req_now       taken when start && !busy
//             req_jitter
//   result    rsp_ok_to_request rsp_entry_found           rsp_valid, one cycle, no stall
//             rsp_next_allowed_time rsp_failures rsp_status
//   config    psel penable pwrite paddr pwdata prdata     APB, pready tied high
//
// A clear goes straight from accept to the finishing state. Query and success walk the key
// store one slot per cycle over its single read port; a query that finds its key then loads
// its record. A failure adds the record load and one shifter moving one bit per cycle, then
// the cap and the saturating add; a failure on a full table skips these. Synchronous reset
// empties the table and restores the register defaults. busy is high from accept through the
// cycle before the strobe; no result stalls.
module retry_backoff_table #(
   parameter int unsigned TABLE_ENTRIES = rbt_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned MAX_EXPONENT  = rbt_pkg::MAX_EXPONENT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_operation,
   input  logic [rbt_pkg::KEY_W-1:0]        req_request_key,
   input  logic [rbt_pkg::TIME_W-1:0]       req_now,
   input  logic [1:0]                       req_jitter,
   // result channel
   output logic                             rsp_valid,
   output logic                             rsp_ok_to_request,
   output logic                             rsp_entry_found,
   output logic [rbt_pkg::TIME_W-1:0]       rsp_next_allowed_time,
   output logic [rbt_pkg::CNT_W-1:0]        rsp_failures,
   output logic [1:0]                       rsp_status,
   // configuration port
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rbt_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rbt_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rbt_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned SH_W  = (MAX_EXPONENT > 1) ? $clog2(MAX_EXPONENT) : 1;
   // widest interval before the cap: base shifted by MAX_EXPONENT - 1
   localparam int unsigned ACC_W = rbt_pkg::BASE_W + MAX_EXPONENT - 1;
   localparam int unsigned CW    = rbt_pkg::CNT_W;
   localparam int unsigned TW    = rbt_pkg::TIME_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,      // issue reads slot by slot
      ST_SCAN_END,  // compare of the last slot
      ST_DECIDE,    // pick hit / free slot, issue record read
      ST_LOAD,      // record data back, new count
      ST_SHIFT,     // base << (exp - 1), one bit per cycle
      ST_CAP,       // clamp to max_retry_interval
      ST_ADD,       // now + interval, saturating
      ST_FINISH     // write back, judge, drive result
   } state_type;

   state_type                   state_ff, state_in;
   rbt_pkg::op_type             op_ff, op_in;
   logic [rbt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [TW-1:0]               now_ff, now_in;
   logic [1:0]                  jit_ff, jit_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]            cmp_idx_ff, cmp_idx_in;
   logic                        hit_ff, hit_in;
   logic [IDX_W-1:0]            hit_idx_ff, hit_idx_in;
   logic                        free_ff, free_in;
   logic [IDX_W-1:0]            free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]            slot_ff, slot_in;
   logic                        has_ff, has_in;
   rbt_pkg::status_type         status_ff, status_in;
   logic [TABLE_ENTRIES-1:0]    valid_ff, valid_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [TW-1:0]               last_ff, last_in;
   logic [TW-1:0]               next_ff, next_in;
   logic [ACC_W-1:0]            acc_ff, acc_in;
   logic [SH_W-1:0]             sh_ff, sh_in;
   logic [rbt_pkg::BASE_W-1:0]  base_ff, base_in;
   logic [rbt_pkg::MAXI_W-1:0]  maxi_ff, maxi_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [TW-1:0]               rsp_next_ff, rsp_next_in;
   logic [CW-1:0]               rsp_cnt_ff, rsp_cnt_in;
   rbt_pkg::status_type         rsp_status_ff, rsp_status_in;

   // store port
   logic                        wr_en;
   rbt_pkg::rec_type            wr_rec;
   logic [IDX_W-1:0]            rd_addr;
   rbt_pkg::rec_type            rd_rec;

   // datapath helpers
   logic                        csr_wr;
   logic                        cmp_hit;
   logic [CW-1:0]               cnt_new;
   logic signed [CW:0]          exp_raw;
   logic [CW:0]                 exp_cap;
   logic [TW:0]                 sum;

   rbt_store #(
      .ENTRIES (TABLE_ENTRIES),
      .AW      (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_rec  (wr_rec),
      .rd_addr (rd_addr),
      .rd_rec  (rd_rec)
   );

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      unique case (rbt_pkg::reg_type'(paddr[3]))
         rbt_pkg::REG_BASE_INTERVAL: prdata = rbt_pkg::CSR_DATA_W'(base_ff);
         rbt_pkg::REG_MAX_RETRY:     prdata = rbt_pkg::CSR_DATA_W'(maxi_ff);
         default:                    prdata = '0;
      endcase
   end

   // scan pipeline: read data at the edge after the address
   assign cmp_hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_rec.key == key_ff);
   assign rd_addr = (state_ff == ST_SCAN) ? idx_ff : slot_in;

   // failure count update and exponent
   assign cnt_new = !hit_ff ? CW'(1) :
                    (rd_rec.count == rbt_pkg::CNT_MAX) ? rbt_pkg::CNT_MAX :
                    rd_rec.count + CW'(1);
   assign exp_raw = $signed({1'b0, cnt_new}) - $signed((CW+1)'(jit_ff));
   assign exp_cap = ($unsigned(exp_raw) > (CW+1)'(MAX_EXPONENT)) ?
                    (CW+1)'(MAX_EXPONENT) : $unsigned(exp_raw);
   assign sum     = {1'b0, now_ff} + (TW+1)'(acc_ff);

   assign wr_rec.key   = key_ff;
   assign wr_rec.count = cnt_ff;
   assign wr_rec.last  = last_ff;
   assign wr_rec.next  = next_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      jit_in        = jit_ff;
      idx_in        = idx_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      slot_in       = slot_ff;
      has_in        = has_ff;
      status_in     = status_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      next_in       = next_ff;
      acc_in        = acc_ff;
      sh_in         = sh_ff;
      base_in       = base_ff;
      maxi_in       = maxi_ff;
      rsp_valid_in  = 1'b0;
      rsp_ok_in     = rsp_ok_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;

      if (csr_wr) begin
         unique case (rbt_pkg::reg_type'(paddr[3]))
            rbt_pkg::REG_BASE_INTERVAL: base_in = pwdata[rbt_pkg::BASE_W-1:0];
            rbt_pkg::REG_MAX_RETRY:     maxi_in = pwdata[rbt_pkg::MAXI_W-1:0];
            default: ;
         endcase
      end

      // first matching slot and first free slot, collected as reads come back
      if (cmp_vld_ff) begin
         if (cmp_hit && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!valid_ff[cmp_idx_ff] && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = cmp_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = rbt_pkg::op_type'(req_operation);
               key_in    = req_request_key;
               now_in    = req_now;
               jit_in    = req_jitter;
               idx_in    = '0;
               hit_in    = 1'b0;
               free_in   = 1'b0;
               has_in    = 1'b0;
               status_in = rbt_pkg::STATUS_NO_CHANGE;
               if (rbt_pkg::op_type'(req_operation) == rbt_pkg::OP_CLEAR) begin
                  valid_in  = '0;
                  status_in = rbt_pkg::STATUS_CHANGED;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_SCAN_END;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            case (op_ff)
               rbt_pkg::OP_QUERY: begin
                  if (hit_ff) begin
                     slot_in  = hit_idx_ff;
                     state_in = ST_LOAD;
                  end
               end
               rbt_pkg::OP_SUCCESS: begin
                  if (hit_ff) begin
                     valid_in[hit_idx_ff] = 1'b0;
                     status_in            = rbt_pkg::STATUS_CHANGED;
                  end
               end
               rbt_pkg::OP_FAILURE: begin
                  if (hit_ff) begin
                     slot_in  = hit_idx_ff;
                     state_in = ST_LOAD;
                  end else if (free_ff) begin
                     slot_in  = free_idx_ff;
                     state_in = ST_LOAD;
                  end else begin
                     status_in = rbt_pkg::STATUS_FULL;
                  end
               end
               default: ;
            endcase
         end
         ST_LOAD: begin
            has_in = 1'b1;
            if (op_ff == rbt_pkg::OP_QUERY) begin
               cnt_in   = rd_rec.count;
               last_in  = rd_rec.last;
               next_in  = rd_rec.next;
               state_in = ST_FINISH;
            end else begin
               cnt_in    = cnt_new;
               last_in   = now_ff;
               status_in = rbt_pkg::STATUS_CHANGED;
               if (exp_raw <= 0) begin
                  acc_in   = '0;
                  state_in = ST_CAP;
               end else begin
                  acc_in   = ACC_W'(base_ff);
                  sh_in    = SH_W'(exp_cap - (CW+1)'(1));
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (sh_ff == '0) begin
               state_in = ST_CAP;
            end else begin
               acc_in = acc_ff << 1;
               sh_in  = sh_ff - SH_W'(1);
            end
         end
         ST_CAP: begin
            // when clamped, max_retry_interval < acc, so it fits in ACC_W
            if ((TW+1)'(acc_ff) > (TW+1)'(maxi_ff)) begin
               acc_in = ACC_W'(maxi_ff);
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            next_in  = sum[TW] ? rbt_pkg::TIME_MAX : sum[TW-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (op_ff == rbt_pkg::OP_FAILURE && has_ff) begin
               wr_en             = 1'b1;
               valid_in[slot_ff] = 1'b1;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            if (has_ff) begin
               rsp_ok_in    = (last_ff > now_ff) || (now_ff >= next_ff);
               rsp_found_in = 1'b1;
               rsp_next_in  = next_ff;
               rsp_cnt_in   = cnt_ff;
            end else begin
               rsp_ok_in    = 1'b1;
               rsp_found_in = 1'b0;
               rsp_next_in  = '0;
               rsp_cnt_in   = '0;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      now_ff        <= now_in;
      jit_ff        <= jit_in;
      idx_ff        <= idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      slot_ff       <= slot_in;
      has_ff        <= has_in;
      status_ff     <= status_in;
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      next_ff       <= next_in;
      acc_ff        <= acc_in;
      sh_ff         <= sh_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         base_ff      <= rbt_pkg::BASE_RESET;
         maxi_ff      <= rbt_pkg::MAXI_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         base_ff      <= base_in;
         maxi_ff      <= maxi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ok_to_request     = rsp_ok_ff;
   assign rsp_entry_found       = rsp_found_ff;
   assign rsp_next_allowed_time = rsp_next_ff;
   assign rsp_failures          = rsp_cnt_ff;
   assign rsp_status            = rsp_status_ff;

endmodule

// ===== rtl/rbt_store.sv =====
// Record store of the retry backoff table: one write port, one registered read port.
// Depends on rbt_pkg (rec_type). No reset: entries are undefined until written.
module rbt_store #(
   parameter int unsigned ENTRIES = rbt_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  rbt_pkg::rec_type wr_rec,
   input  logic [AW-1:0]    rd_addr,
   output rbt_pkg::rec_type rd_rec
);

   rbt_pkg::rec_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_rec;
      end
      rd_rec <= mem[rd_addr];
   end

endmodule

// ===== rtl/rbt_checker.sv =====
// Port-level checks for retry_backoff_table, attached by the bind below.
// Depends on rbt_pkg and the top level's ports.
module rbt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic                            rsp_ok_to_request,
   input logic                            rsp_entry_found,
   input logic [rbt_pkg::TIME_W-1:0]      rsp_next_allowed_time,
   input logic [rbt_pkg::CNT_W-1:0]       rsp_failures,
   input logic [1:0]                      rsp_status
);

   // result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // no record: allowed, zero time and count
   a_no_record: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_entry_found) |->
         (rsp_ok_to_request && rsp_failures == '0 && rsp_next_allowed_time == '0))
      else $error("missing record reported with nonzero fields");

   // a live record has at least one failure and never a full-table status
   a_record_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_entry_found) |->
         (rsp_failures != '0 && rsp_status != rbt_pkg::STATUS_FULL))
      else $error("found record with zero failures or full status");

   // dropped failure never reports a record
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == rbt_pkg::STATUS_FULL) |-> !rsp_entry_found)
      else $error("table full but record reported");

endmodule

bind retry_backoff_table rbt_checker u_rbt_checker (
   .clock                 (clock),
   .reset                 (reset),
   .start                 (start),
   .busy                  (busy),
   .rsp_valid             (rsp_valid),
   .rsp_ok_to_request     (rsp_ok_to_request),
   .rsp_entry_found       (rsp_entry_found),
   .rsp_next_allowed_time (rsp_next_allowed_time),
   .rsp_failures          (rsp_failures),
   .rsp_status            (rsp_status)
);

// ===== sim/tb_retry_backoff_table.sv =====
// Self-checking testbench for retry_backoff_table: request driver, result monitor, CSR port.
// Holds its own shadow of the retry table and backoff registers to predict every result.
// Depends on rbt_pkg and the retry_backoff_table RTL.
module tb_retry_backoff_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_MAX  = 10;
   localparam int NTAB        = int'(rbt_pkg::TABLE_ENTRIES_DEF);
   localparam int POOL_N      = 20;   // more keys than slots, so the table can fill

   typedef struct {
      rbt_pkg::op_type            op;
      logic [rbt_pkg::KEY_W-1:0]  key;
      logic [rbt_pkg::TIME_W-1:0] now;
      logic [1:0]                 jitter;
   } table_req_type;

   typedef struct {
      logic                       ok;
      logic                       found;
      logic [rbt_pkg::TIME_W-1:0] nxt;
      logic [rbt_pkg::CNT_W-1:0]  fails;
      rbt_pkg::status_type        st;
   } table_rsp_type;

   // ---------------------------------------------------------------- DUT signals
   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   logic [1:0]                     req_operation = '0;
   logic [rbt_pkg::KEY_W-1:0]      req_request_key = '0;
   logic [rbt_pkg::TIME_W-1:0]     req_now = '0;
   logic [1:0]                     req_jitter = '0;
   logic                           rsp_valid;
   logic                           rsp_ok_to_request;
   logic                           rsp_entry_found;
   logic [rbt_pkg::TIME_W-1:0]     rsp_next_allowed_time;
   logic [rbt_pkg::CNT_W-1:0]      rsp_failures;
   logic [1:0]                     rsp_status;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [rbt_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [rbt_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [rbt_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   retry_backoff_table u_top (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_request_key       (req_request_key),
      .req_now               (req_now),
      .req_jitter            (req_jitter),
      .rsp_valid             (rsp_valid),
      .rsp_ok_to_request     (rsp_ok_to_request),
      .rsp_entry_found       (rsp_entry_found),
      .rsp_next_allowed_time (rsp_next_allowed_time),
      .rsp_failures          (rsp_failures),
      .rsp_status            (rsp_status),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- shadow table
   // Mirror of the record table and both backoff registers, updated in accept order.
   logic                       shadow_valid [NTAB];
   logic [rbt_pkg::KEY_W-1:0]  shadow_key   [NTAB];
   logic [rbt_pkg::CNT_W-1:0]  shadow_count [NTAB];
   logic [rbt_pkg::TIME_W-1:0] shadow_last  [NTAB];
   logic [rbt_pkg::TIME_W-1:0] shadow_next  [NTAB];
   logic [rbt_pkg::BASE_W-1:0] shadow_base;
   logic [rbt_pkg::MAXI_W-1:0] shadow_max_ivl;

   table_req_type pending_reqs[$];    // requests waiting for the driver
   table_rsp_type expected_rsps[$];   // predicted results, oldest first
   table_req_type on_port;            // request currently presented on req_*

   int  mismatches = 0;
   int  results_seen = 0;
   int  cycle_count = 0;
   int  op_seen [4] = '{0, 0, 0, 0};
   int  n_full = 0;
   int  n_count_held = 0;
   int  n_time_clamped = 0;
   int  n_csr_writes = 0;
   int  gap_left = 0;
   bit  quiet = 1'b0;
   logic [63:0] wall_ms = '0;       // running time base for generated requests

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Truncated binary exponential backoff: base << (count - jitter - 1), exponent capped.
   function automatic logic [63:0] backoff_ivl(input logic [rbt_pkg::CNT_W-1:0] cnt,
                                               input logic [1:0] jit);
      int          e;
      logic [63:0] v;
      e = int'(cnt) - int'(jit);
      if (e <= 0) return '0;
      if (e > int'(rbt_pkg::MAX_EXPONENT_DEF)) e = int'(rbt_pkg::MAX_EXPONENT_DEF);
      v = 64'(shadow_base) << (e - 1);
      if (v > 64'(shadow_max_ivl)) v = 64'(shadow_max_ivl);
      return v;
   endfunction

   // Apply one accepted request to the shadow table and queue the result it must produce.
   function automatic void predict_table_op(input table_req_type r);
      int                  hit;
      logic [63:0]         nt;
      table_rsp_type       res;
      rbt_pkg::status_type st;
      hit = -1;
      st  = rbt_pkg::STATUS_NO_CHANGE;
      op_seen[int'(r.op)]++;
      for (int i = 0; i < NTAB; i++)
         if (hit < 0 && shadow_valid[i] && shadow_key[i] == r.key) hit = i;
      case (r.op)
         rbt_pkg::OP_SUCCESS: begin
            if (hit >= 0) begin
               shadow_valid[hit] = 1'b0;
               st  = rbt_pkg::STATUS_CHANGED;
               hit = -1;
            end
         end
         rbt_pkg::OP_FAILURE: begin
            if (hit < 0) begin
               // new key: lowest free slot, count starts from zero
               for (int i = 0; i < NTAB; i++)
                  if (hit < 0 && !shadow_valid[i]) hit = i;
               if (hit >= 0) begin
                  shadow_valid[hit] = 1'b1;
                  shadow_key[hit]   = r.key;
                  shadow_count[hit] = '0;
               end
            end
            if (hit >= 0) begin
               if (shadow_count[hit] != rbt_pkg::CNT_MAX) shadow_count[hit]++;
               else n_count_held++;
               shadow_last[hit] = r.now;
               nt = 64'(r.now) + backoff_ivl(shadow_count[hit], r.jitter);
               if (nt > 64'(rbt_pkg::TIME_MAX)) begin
                  nt = 64'(rbt_pkg::TIME_MAX);
                  n_time_clamped++;
               end
               shadow_next[hit] = nt[rbt_pkg::TIME_W-1:0];
               st = rbt_pkg::STATUS_CHANGED;
            end else begin
               st = rbt_pkg::STATUS_FULL;
               n_full++;
            end
         end
         rbt_pkg::OP_CLEAR: begin
            for (int i = 0; i < NTAB; i++) shadow_valid[i] = 1'b0;
            st  = rbt_pkg::STATUS_CHANGED;
            hit = -1;
         end
         default: ;
      endcase
      if (hit >= 0) begin
         res.ok    = (shadow_last[hit] > r.now) || (r.now >= shadow_next[hit]);
         res.found = 1'b1;
         res.nxt   = shadow_next[hit];
         res.fails = shadow_count[hit];
      end else begin
         res.ok    = 1'b1;
         res.found = 1'b0;
         res.nxt   = '0;
         res.fails = '0;
      end
      res.st = st;
      expected_rsps.push_back(res);
   endfunction

   // ---------------------------------------------------------------- stimulus helpers
   function automatic void add_req(input rbt_pkg::op_type op,
                                   input logic [rbt_pkg::KEY_W-1:0] key,
                                   input logic [rbt_pkg::TIME_W-1:0] now,
                                   input logic [1:0] jit);
      table_req_type r;
      r.op     = op;
      r.key    = key;
      r.now    = now;
      r.jitter = jit;
      pending_reqs.push_back(r);
   endfunction

   // Walk time forward on the scale of the current backoff, with occasional steps back
   // (last failure after now), jumps anywhere and jumps to the top of the time range.
   function automatic logic [rbt_pkg::TIME_W-1:0] next_now(input logic [63:0] span);
      int unsigned pick;
      logic [63:0] step;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         wall_ms = wall_ms + rand64() % ((span >> 3) + 1);
      end else if (pick < 85) begin
         wall_ms = wall_ms + rand64() % (2 * span + 1);
      end else if (pick < 92) begin
         step = rand64() % (span + 1);
         wall_ms = (wall_ms > step) ? wall_ms - step : '0;
      end else if (pick < 96) begin
         wall_ms = rand64() & 64'(rbt_pkg::TIME_MAX);
      end else begin
         wall_ms = 64'(rbt_pkg::TIME_MAX) - 64'($urandom_range(0, 255));
      end
      if (wall_ms > 64'(rbt_pkg::TIME_MAX)) wall_ms = 64'(rbt_pkg::TIME_MAX);
      return wall_ms[rbt_pkg::TIME_W-1:0];
   endfunction

   // Random traffic over a fresh key pool; odd pool keys differ from an anchor in one bit
   // so the key compare gets exercised, plus all-zero and all-one keys.
   task automatic queue_traffic(input int n);
      logic [rbt_pkg::KEY_W-1:0] pool [POOL_N];
      logic [rbt_pkg::KEY_W-1:0] anchor;
      logic [63:0]               span;
      int unsigned               pick;
      rbt_pkg::op_type           op;
      anchor = $urandom;
      foreach (pool[i])
         pool[i] = (i % 2) ? anchor ^ (32'd1 << $urandom_range(0, 31)) : $urandom;
      pool[0] = '0;
      pool[1] = '1;
      span = 64'(shadow_base) << (rbt_pkg::MAX_EXPONENT_DEF - 1);
      if (span > 64'(shadow_max_ivl)) span = 64'(shadow_max_ivl);
      if (span < 16) span = 16;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         op = (pick < 45) ? rbt_pkg::OP_FAILURE : (pick < 70) ? rbt_pkg::OP_QUERY :
              (pick < 97) ? rbt_pkg::OP_SUCCESS : rbt_pkg::OP_CLEAR;
         add_req(op, ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, POOL_N-1)],
                 next_now(span), 2'($urandom_range(0, 3)));
      end
   endtask

   // Mostly short gaps, some medium, a few long; now and then a burst with none at all.
   function automatic int pick_gap();
      int unsigned pick;
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      if (quiet) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(0, 2);
      if (pick < 90) return $urandom_range(3, 20);
      return $urandom_range(21, 60);
   endfunction

   // Wait until the driver has nothing left and every predicted result has come back.
   // Checked on the falling edge so the driver's updates of the same edge have settled.
   task automatic drain();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // APB write (setup + access), then read the register back through prdata.
   task automatic program_csr(input rbt_pkg::reg_type idx, input logic [63:0] value);
      logic [63:0] want;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);   // write lands on this edge
      if (idx == rbt_pkg::REG_BASE_INTERVAL) shadow_base = value[rbt_pkg::BASE_W-1:0];
      else shadow_max_ivl = value[rbt_pkg::MAXI_W-1:0];
      want = (idx == rbt_pkg::REG_BASE_INTERVAL) ? 64'(shadow_base) : 64'(shadow_max_ivl);
      n_csr_writes++;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("csr readback %s: expected %h, got %h", idx.name(), want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---------------------------------------------------------------- request driver
   // A request on the ports is taken at an edge with start high and busy low; the
   // prediction is made right there so the shadow follows the block's accept order.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) predict_table_op(on_port);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               on_port = pending_reqs.pop_front();
               start           <= 1'b1;
               req_operation   <= on_port.op;
               req_request_key <= on_port.key;
               req_now         <= on_port.now;
               req_jitter      <= on_port.jitter;
               gap_left = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- result monitor
   // Results cannot be held off, so every strobe is consumed on the edge that ends it.
   always @(posedge clock) begin
      table_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         results_seen++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("%0t: result with nothing outstanding (status %0d)", $realtime,
                        rsp_status);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ok_to_request !== want.ok || rsp_entry_found !== want.found ||
                rsp_next_allowed_time !== want.nxt || rsp_failures !== want.fails ||
                rsp_status !== want.st) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: result %0d exp ok=%0b found=%0b next=%h fails=%0d st=%0d",
                           $realtime, results_seen, want.ok, want.found, want.nxt,
                           want.fails, want.st);
               if (mismatches <= REPORT_MAX)
                  $display("              got ok=%0b found=%0b next=%h fails=%0d st=%0d",
                           rsp_ok_to_request, rsp_entry_found, rsp_next_allowed_time,
                           rsp_failures, rsp_status);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_rsps.size());
         $display("retry_backoff_table test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- test sequence
   initial begin
      logic [rbt_pkg::KEY_W-1:0] hammer_key;
      shadow_base    = rbt_pkg::BASE_RESET;
      shadow_max_ivl = rbt_pkg::MAXI_RESET;
      for (int i = 0; i < NTAB; i++) shadow_valid[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed pass with reset register values
      add_req(rbt_pkg::OP_QUERY,   '0, '0, 2'd0);          // no record yet
      add_req(rbt_pkg::OP_SUCCESS, '0, '0, 2'd0);          // success on missing key
      add_req(rbt_pkg::OP_FAILURE, '0, '0, 2'd0);          // first failure, one base interval
      add_req(rbt_pkg::OP_QUERY,   '0, 48'd29999, 2'd0);   // one ms short of next allowed
      add_req(rbt_pkg::OP_QUERY,   '0, 48'd30000, 2'd0);   // exactly at next allowed
      add_req(rbt_pkg::OP_FAILURE, '0, 48'd100, 2'd3);     // jitter pushes exponent below one
      add_req(rbt_pkg::OP_FAILURE, '1, rbt_pkg::TIME_MAX, 2'd0);  // next allowed saturates
      add_req(rbt_pkg::OP_QUERY,   '1, 48'd5, 2'd3);       // last failure lies after now
      add_req(rbt_pkg::OP_SUCCESS, '1, 48'd6, 2'd1);       // erase a present record
      for (int i = 0; i < NTAB - 1; i++)                   // fill every remaining slot
         add_req(rbt_pkg::OP_FAILURE, 32'h1000 + i, 48'(5000 * i), 2'(i));
      add_req(rbt_pkg::OP_FAILURE, 32'hDEAD_BEEF, 48'd9, 2'd0);   // table full, dropped
      add_req(rbt_pkg::OP_CLEAR,   '0, '0, 2'd0);
      add_req(rbt_pkg::OP_CLEAR,   '1, '1, 2'd3);          // clear on an empty table
      drain();

      // Base of one, no cap: one key hammered past count saturation and exponent cap
      program_csr(rbt_pkg::REG_BASE_INTERVAL, 64'd1);
      program_csr(rbt_pkg::REG_MAX_RETRY, 64'(rbt_pkg::MAXI_RESET) | 64'hFF_FFFF_FFFF);
      hammer_key = $urandom;
      for (int i = 0; i < 270; i++) begin
         add_req(rbt_pkg::OP_FAILURE, hammer_key, next_now(64'd16384),
                 2'($urandom_range(0, 3)));
         if ($urandom_range(0, 9) == 0)
            add_req(rbt_pkg::OP_QUERY, hammer_key, next_now(64'd16384),
                    2'($urandom_range(0, 3)));
      end
      queue_traffic(60);
      drain();

      // Both registers at their top values
      program_csr(rbt_pkg::REG_BASE_INTERVAL, 64'hFF_FFFF);
      queue_traffic(100);
      drain();

      // Zero base: every interval collapses to zero
      program_csr(rbt_pkg::REG_BASE_INTERVAL, 64'd0);
      program_csr(rbt_pkg::REG_MAX_RETRY, rand64());
      queue_traffic(90);
      drain();

      // Zero cap with a random base
      program_csr(rbt_pkg::REG_BASE_INTERVAL, rand64());
      program_csr(rbt_pkg::REG_MAX_RETRY, 64'd0);
      queue_traffic(90);
      drain();

      // Back to the reset defaults
      program_csr(rbt_pkg::REG_BASE_INTERVAL, 64'(rbt_pkg::BASE_RESET));
      program_csr(rbt_pkg::REG_MAX_RETRY, 64'(rbt_pkg::MAXI_RESET));
      queue_traffic(100);
      drain();

      // Random settings, small cap so it clips often
      program_csr(rbt_pkg::REG_BASE_INTERVAL, rand64());
      program_csr(rbt_pkg::REG_MAX_RETRY, 64'($urandom_range(1, 1 << 20)));
      queue_traffic(100);
      drain();

      // Let any stray strobe show up before closing
      repeat (40) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         mismatches++;
         $display("%0d predicted results never arrived", expected_rsps.size());
      end
      $display("covered %0d requests (query %0d, success %0d, failure %0d, clear %0d)",
               op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3], op_seen[0], op_seen[1],
               op_seen[2], op_seen[3]);
      $display("%0d results, %0d full-table drops, count held at max %0d, time clamped %0d,",
               results_seen, n_full, n_count_held, n_time_clamped);
      $display("%0d csr writes, %0d mismatches", n_csr_writes, mismatches);
      if (mismatches == 0)
         $display("retry_backoff_table test passed");
      else
         $display("retry_backoff_table test failed");
      $finish;
   end

endmodule
